// ----- src/cpmt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpmt_pkg
// Shared types and constants of the CIDR prefix match table.
// ---------------------------------------------------------------------------
package cpmt_pkg;

  localparam int NET_W     = 32;
  localparam int PFX_W     = 6;
  localparam int PLEN_W    = 8;
  localparam int CNT_OUT_W = 7;
  localparam int PFX_MAX   = 32;
  localparam int ENTRY_W   = NET_W + PFX_W;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BADPREFIX = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUP       = 3'd3,
    ST_NOTFOUND  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_RDLAST,
    S_MOVE,
    S_APPEND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic covers;
    logic exact;
  } cmp_res_t;

endpackage : cpmt_pkg
`default_nettype wire

// ----- src/cpmt_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpmt_req_if
// Request channel: mode, address and prefix length with valid/ready.
// ---------------------------------------------------------------------------
interface cpmt_req_if;

  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [31:0] address;
  logic [7:0] prefix_length;

  modport source (output valid, output mode, output address, output prefix_length,
                  input ready);
  modport sink   (input valid, input mode, input address, input prefix_length,
                  output ready);

endinterface : cpmt_req_if
`default_nettype wire

// ----- src/cpmt_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpmt_rsp_if
// Result channel: match flag, status code and entry count with valid/ready.
// ---------------------------------------------------------------------------
interface cpmt_rsp_if;

  logic       valid;
  logic       ready;
  logic       matched;
  logic [2:0] status;
  logic [6:0] entry_count;

  modport source (output valid, output matched, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input matched, input status, input entry_count,
                  output ready);

endinterface : cpmt_rsp_if
`default_nettype wire

// ----- src/cidr_prefix_match_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cidr_prefix_match_table_unit
// IPv4 network/prefix table with lookup, add and remove requests.
// ---------------------------------------------------------------------------
//  channel | dir | fields                                 | handshake
//  in_req  | in  | mode[1:0] address[31:0] prefix_length[7:0] | valid/ready
//  out_rsp | out | matched status[2:0] entry_count[6:0]   | valid/ready
//
//  A request walks the stored entries one at a time through the single RAM
//  read port and the shared compare unit, reading then comparing each entry;
//  an add that appends writes the new entry after the walk, and a remove of
//  any entry but the last reads the last entry and moves it into the hole.
//  Requests are taken only between items. Synchronous active-low
//  reset empties the table at once. A held result stalls the next item at
//  its end only.
// ---------------------------------------------------------------------------
module cidr_prefix_match_table_unit
  import cpmt_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cpmt_req_if.sink    in_req,
  cpmt_rsp_if.source  out_rsp
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  state_t            state_r, state_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [NET_W-1:0]  addr_r, addr_nxt;
  logic [PLEN_W-1:0] plen_r, plen_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              matched_r, matched_nxt;
  status_t           status_r, status_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_matched_r, out_matched_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [CW-1:0]     out_count_r, out_count_nxt;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data, rd_data;
  cmp_res_t          cmp;
  logic              hit, is_last, out_free;
  logic [AW-1:0]     last_idx;

  cpmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cpmt_cmp u_cmp (
    .key_addr (addr_r),
    .key_plen (plen_r),
    .ent_net  (rd_data[ENTRY_W-1:PFX_W]),
    .ent_pfx  (rd_data[PFX_W-1:0]),
    .res      (cmp)
  );

  assign last_idx = AW'(count_r - CW'(1));
  assign is_last  = (idx_r == last_idx);
  assign hit      = (mode_r == MODE_LOOKUP) ? cmp.covers : cmp.exact;
  assign out_free = !out_valid_r || out_rsp.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          case (in_req.mode)
            MODE_LOOKUP: state_nxt = (count_r == '0) ? S_DONE : S_RD;
            MODE_ADD: begin
              if (in_req.prefix_length > PLEN_W'(PFX_MAX) ||
                  count_r == CW'(MAX_ENTRIES)) begin
                state_nxt = S_DONE;
              end else if (count_r == '0) begin
                state_nxt = S_APPEND;
              end else begin
                state_nxt = S_RD;
              end
            end
            MODE_REMOVE: state_nxt = (count_r == '0) ? S_DONE : S_RD;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_RD:  state_nxt = S_CMP;
      S_CMP: begin
        if (hit) begin
          state_nxt = (mode_r == MODE_REMOVE && !is_last) ? S_RDLAST : S_DONE;
        end else if (is_last) begin
          state_nxt = (mode_r == MODE_ADD) ? S_APPEND : S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RDLAST: state_nxt = S_MOVE;
      S_MOVE:   state_nxt = S_DONE;
      S_APPEND: state_nxt = S_DONE;
      S_DONE:   state_nxt = out_free ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_req.ready = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = idx_r;
    wr_en        = 1'b0;
    wr_addr      = idx_r;
    wr_data      = rd_data;
    case (state_r)
      S_IDLE: in_req.ready = 1'b1;
      S_RD:   rd_en = 1'b1;
      S_RDLAST: begin
        rd_en   = 1'b1;
        rd_addr = last_idx;
      end
      S_MOVE: wr_en = 1'b1;
      S_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = AW'(count_r);
        wr_data = {addr_r, plen_r[PFX_W-1:0]};
      end
      default: ;
    endcase
  end

  // request and result datapath
  always_comb begin
    mode_nxt        = mode_r;
    addr_nxt        = addr_r;
    plen_nxt        = plen_r;
    idx_nxt         = idx_r;
    count_nxt       = count_r;
    matched_nxt     = matched_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_matched_nxt = out_matched_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    case (state_r)
      S_IDLE: begin
        mode_nxt    = in_req.mode;
        addr_nxt    = in_req.address;
        plen_nxt    = in_req.prefix_length;
        idx_nxt     = '0;
        matched_nxt = 1'b0;
        status_nxt  = ST_OK;
        if (in_req.mode == MODE_ADD) begin
          if (in_req.prefix_length > PLEN_W'(PFX_MAX)) begin
            status_nxt = ST_BADPREFIX;
          end else if (count_r == CW'(MAX_ENTRIES)) begin
            status_nxt = ST_FULL;
          end
        end else if (in_req.mode == MODE_REMOVE && count_r == '0) begin
          status_nxt = ST_NOTFOUND;
        end
      end
      S_CMP: begin
        if (hit) begin
          case (mode_r)
            MODE_LOOKUP: matched_nxt = 1'b1;
            MODE_ADD:    status_nxt  = ST_DUP;
            MODE_REMOVE: begin
              if (is_last) begin
                count_nxt = count_r - CW'(1);
              end
            end
            default: ;
          endcase
        end else if (is_last) begin
          if (mode_r == MODE_REMOVE) begin
            status_nxt = ST_NOTFOUND;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_MOVE:   count_nxt = count_r - CW'(1);
      S_APPEND: count_nxt = count_r + CW'(1);
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_matched_nxt = matched_r;
          out_status_nxt  = status_r;
          out_count_nxt   = count_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    addr_r        <= addr_nxt;
    plen_r        <= plen_nxt;
    idx_r         <= idx_nxt;
    matched_r     <= matched_nxt;
    status_r      <= status_nxt;
    out_matched_r <= out_matched_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.matched     = out_matched_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.entry_count = CNT_OUT_W'(out_count_r);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_append_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPEND) |=> (count_r == CW'($past(count_r) + CW'(1))))
    else $error("append did not grow the table by one");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !wr_en)
    else $error("table written between items");
`endif

endmodule : cidr_prefix_match_table_unit
`default_nettype wire

// ----- src/cpmt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpmt_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module cpmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : cpmt_ram
`default_nettype wire

// ----- src/cpmt_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cpmt_cmp
// Shared compare unit: prefix cover test and exact pair match of one entry.
// ---------------------------------------------------------------------------
module cpmt_cmp
  import cpmt_pkg::*;
(
  input  wire logic [NET_W-1:0]  key_addr,
  input  wire logic [PLEN_W-1:0] key_plen,
  input  wire logic [NET_W-1:0]  ent_net,
  input  wire logic [PFX_W-1:0]  ent_pfx,
  output cmp_res_t               res
);

  logic [NET_W-1:0] mask;

  // stored prefix is 0..32; a shift of 32 leaves the whole mask set
  assign mask = ~({NET_W{1'b1}} >> ent_pfx);

  always_comb begin
    res.covers = ((key_addr ^ ent_net) & mask) == '0;
    res.exact  = (key_addr == ent_net) && ({{(PLEN_W-PFX_W){1'b0}}, ent_pfx} == key_plen);
  end

endmodule : cpmt_cmp
`default_nettype wire

// ----- sim/cidr_prefix_match_table_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cidr_prefix_match_table_unit_tb
// Self-checking bench for the CIDR prefix match table. A directed run covers
// field extremes, every request mode, duplicate, bad-prefix and
// not-found cases. A long random run follows, shaped to grow, churn and
// shrink the table. Each accepted request updates a local table model that
// predicts the response, and responses are checked field by field in order.
// Both channels idle and stall at random, with one long response hold-off
// and one pause that lets the block drain completely.
// ---------------------------------------------------------------------------
module cidr_prefix_match_table_unit_tb;
  import cpmt_pkg::*;

  localparam int          TABLE_DEPTH = 64;
  localparam int          RAND_ITEMS  = 1850;
  localparam int          IDLE_LIMIT  = 3000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          HOLD_AT     = 500;
  localparam int          DRAIN_AT    = 900;
  localparam int          TAIL_CYCLES = 300;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [7:0]  prefix_length;
    bit          drain;
  } lookup_req_t;

  typedef struct {
    logic    matched;
    status_t status;
    logic [6:0] entry_count;
  } lookup_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  cpmt_req_if req_if ();
  cpmt_rsp_if rsp_if ();

  cidr_prefix_match_table_unit #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table model used for prediction
  logic [31:0] tbl_net [TABLE_DEPTH];
  logic [5:0]  tbl_pfx [TABLE_DEPTH];
  int          tbl_cnt = 0;

  // shadow of table contents used only to shape stimulus
  logic [31:0] pool_net [$];
  logic [7:0]  pool_pfx [$];

  lookup_req_t pending_reqs [$];
  lookup_rsp_t expected_rsps [$];
  int          fail_cnt = 0;

  function automatic bit net_covered(logic [31:0] a, logic [31:0] net, int plen);
    logic [31:0] mask;
    if (plen == 0) return 1'b1;
    if (plen >= 32) return a == net;
    mask = 32'hFFFF_FFFF << (32 - plen);
    return (a & mask) == (net & mask);
  endfunction

  function automatic int tbl_find(logic [31:0] net, logic [7:0] plen);
    for (int i = 0; i < tbl_cnt; i++)
      if (tbl_net[i] == net && 8'(tbl_pfx[i]) == plen) return i;
    return -1;
  endfunction

  function automatic lookup_rsp_t predict_rsp(logic [1:0] md, logic [31:0] a,
                                              logic [7:0] plen);
    lookup_rsp_t r;
    int          idx;
    r.matched = 1'b0;
    r.status  = ST_OK;
    case (md)
      MODE_LOOKUP: begin
        for (int i = 0; i < tbl_cnt; i++)
          if (net_covered(a, tbl_net[i], int'(tbl_pfx[i]))) r.matched = 1'b1;
      end
      MODE_ADD: begin
        if (plen > PFX_MAX) r.status = ST_BADPREFIX;
        else if (tbl_cnt >= TABLE_DEPTH) r.status = ST_FULL;
        else if (tbl_find(a, plen) >= 0) r.status = ST_DUP;
        else begin
          tbl_net[tbl_cnt] = a;
          tbl_pfx[tbl_cnt] = plen[5:0];
          tbl_cnt++;
        end
      end
      MODE_REMOVE: begin
        idx = tbl_find(a, plen);
        if (idx < 0) r.status = ST_NOTFOUND;
        else begin
          tbl_net[idx] = tbl_net[tbl_cnt - 1];
          tbl_pfx[idx] = tbl_pfx[tbl_cnt - 1];
          tbl_cnt--;
        end
      end
      default: ;
    endcase
    r.entry_count = 7'(tbl_cnt);
    return r;
  endfunction

  function automatic int pool_find(logic [31:0] net, logic [7:0] plen);
    foreach (pool_net[i])
      if (pool_net[i] == net && pool_pfx[i] == plen) return i;
    return -1;
  endfunction

  task automatic queue_req(logic [1:0] md, logic [31:0] a, logic [7:0] plen,
                           bit drain = 1'b0);
    lookup_req_t q;
    int          idx;
    q.mode = md;
    q.address = a;
    q.prefix_length = plen;
    q.drain = drain;
    pending_reqs.push_back(q);
    idx = pool_find(a, plen);
    if (md == MODE_ADD && plen <= PFX_MAX && pool_net.size() < TABLE_DEPTH && idx < 0) begin
      pool_net.push_back(a);
      pool_pfx.push_back(plen);
    end else if (md == MODE_REMOVE && idx >= 0) begin
      pool_net.delete(idx);
      pool_pfx.delete(idx);
    end
  endtask

  function automatic logic [7:0] rand_add_prefix();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 8'($urandom_range(0, 7));
    if (sel < 88) return 8'($urandom_range(8, 32));
    return 8'($urandom_range(33, 255));
  endfunction

  task automatic queue_random_req(int n);
    int          seg, sel, k, pl;
    logic [31:0] a, host;
    logic [7:0]  p;
    seg = (n / 150) % 3;
    sel = $urandom_range(0, 99);
    k = (pool_net.size() > 0) ? $urandom_range(0, pool_net.size() - 1) : -1;
    if (sel < 5) begin
      queue_req(MODE_UNUSED, $urandom, 8'($urandom));
    end else if (sel < (seg == 0 ? 35 : 50)) begin
      p = 8'($urandom);
      if (k >= 0 && $urandom_range(0, 9) < 7) begin
        pl = int'(pool_pfx[k]);
        host = 32'hFFFF_FFFF >> pl;
        a = pool_net[k] ^ ($urandom & host);
        if (pl > 0 && $urandom_range(0, 9) < 3)
          a = a ^ (32'h8000_0000 >> $urandom_range(0, pl - 1));
        queue_req(MODE_LOOKUP, a, p);
      end else
        queue_req(MODE_LOOKUP, $urandom, p);
    end else if (sel < (seg == 0 ? 85 : (seg == 1 ? 75 : 62))) begin
      sel = $urandom_range(0, 99);
      if (k >= 0 && sel < 15)
        queue_req(MODE_ADD, pool_net[k], pool_pfx[k]);
      else if (k >= 0 && sel < 35)
        queue_req(MODE_ADD, pool_net[k] ^ (32'h1 << $urandom_range(0, 7)), rand_add_prefix());
      else
        queue_req(MODE_ADD, $urandom, rand_add_prefix());
    end else begin
      sel = $urandom_range(0, 99);
      if (k >= 0 && sel < 70)
        queue_req(MODE_REMOVE, pool_net[k], pool_pfx[k]);
      else if (k >= 0 && sel < 85)
        queue_req(MODE_REMOVE, pool_net[k], 8'($urandom));
      else
        queue_req(MODE_REMOVE, $urandom, 8'($urandom_range(0, 40)));
    end
  endtask

  // request driver
  int          req_wait = 0;
  int          req_sent = 0;
  lookup_req_t req_next;
  lookup_rsp_t req_pred;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      req_wait = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        req_pred = predict_rsp(req_if.mode, req_if.address, req_if.prefix_length);
        expected_rsps.push_back(req_pred);
        req_sent++;
        req_wait = ((req_sent / 120) % 4 == 3) ? 0 : $urandom_range(0, 8);
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_wait > 0) begin
          req_wait--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_rsps.size() != 0)) begin
          req_next = pending_reqs.pop_front();
          req_if.valid         <= 1'b1;
          req_if.mode          <= req_next.mode;
          req_if.address       <= req_next.address;
          req_if.prefix_length <= req_next.prefix_length;
        end else
          req_if.valid <= 1'b0;
      end
    end
  end

  // response monitor
  int          rsp_stall = 0;
  int          rsp_seen = 0;
  lookup_rsp_t rsp_exp;

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          fail_cnt++;
        end else begin
          rsp_exp = expected_rsps.pop_front();
          if (rsp_if.matched !== rsp_exp.matched) begin
            $error("matched: expected %0d, actual %0d", rsp_exp.matched, rsp_if.matched);
            fail_cnt++;
          end
          if (rsp_if.status !== rsp_exp.status) begin
            $error("status: expected %0d, actual %0d", rsp_exp.status, rsp_if.status);
            fail_cnt++;
          end
          if (rsp_if.entry_count !== rsp_exp.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   rsp_exp.entry_count, rsp_if.entry_count);
            fail_cnt++;
          end
        end
        rsp_seen++;
        if (rsp_seen == HOLD_AT) rsp_stall = HOLD_CYCLES;
        else if ((rsp_seen / 100) % 4 == 3) rsp_stall = 0;
        else rsp_stall = $urandom_range(0, 8);
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else
        rsp_if.ready <= 1'b1;
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("cidr_prefix_match_table_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;

    // directed
    queue_req(MODE_LOOKUP, 32'h0000_0000, 8'hFF);
    queue_req(MODE_REMOVE, 32'h0000_0000, 8'd0);
    queue_req(MODE_ADD,    32'h0A01_0203, 8'd24);
    queue_req(MODE_LOOKUP, 32'h0A01_02C8, 8'd0);
    queue_req(MODE_LOOKUP, 32'h0A01_0301, 8'd24);
    queue_req(MODE_ADD,    32'hFFFF_FFFF, 8'd32);
    queue_req(MODE_LOOKUP, 32'hFFFF_FFFF, 8'd32);
    queue_req(MODE_LOOKUP, 32'hFFFF_FFFE, 8'd32);
    queue_req(MODE_ADD,    32'h0A01_0203, 8'd24);
    queue_req(MODE_ADD,    32'h0A01_0200, 8'd24);
    queue_req(MODE_ADD,    32'h0000_0000, 8'd33);
    queue_req(MODE_ADD,    32'hFFFF_FFFF, 8'hFF);
    queue_req(MODE_REMOVE, 32'h0A01_0204, 8'd24);
    queue_req(MODE_REMOVE, 32'hFFFF_FFFF, 8'd33);
    queue_req(MODE_REMOVE, 32'h0A01_0203, 8'd24);
    queue_req(MODE_LOOKUP, 32'h0A01_0209, 8'd0);
    queue_req(MODE_UNUSED, 32'hFFFF_FFFF, 8'hFF);
    queue_req(MODE_ADD,    32'h8000_0000, 8'd1);
    queue_req(MODE_LOOKUP, 32'hC000_0001, 8'd0);
    queue_req(MODE_ADD,    32'h1234_5678, 8'd0);
    queue_req(MODE_LOOKUP, 32'h0000_0000, 8'd0);
    queue_req(MODE_REMOVE, 32'h1234_5678, 8'd0);
    queue_req(MODE_LOOKUP, 32'h0000_0000, 8'd0);
    queue_req(MODE_REMOVE, 32'h8000_0000, 8'd1);
    queue_req(MODE_LOOKUP, 32'h8000_0000, 8'd1);

    // random: grow, churn and shrink segments
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == DRAIN_AT) pending_reqs.push_back('{MODE_LOOKUP, $urandom, 8'($urandom), 1'b1});
      else queue_random_req(n);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("cidr_prefix_match_table_unit_tb: PASS");
    else
      $display("cidr_prefix_match_table_unit_tb: FAIL");
    $finish;
  end

endmodule : cidr_prefix_match_table_unit_tb

// ----- cidr_prefix_match_table_unit.f -----
src/cpmt_pkg.sv
src/cpmt_req_if.sv
src/cpmt_rsp_if.sv
src/cpmt_ram.sv
src/cpmt_cmp.sv
src/cidr_prefix_match_table_unit.sv
sim/cidr_prefix_match_table_unit_tb.sv
